// ===== design/tcgr_pkg.sv =====
// Shared types and constants for the text cell glyph renderer.
// No dependencies; imported by every module of the block but the generic RAM.
package tcgr_pkg;

    // Glyph store geometry
    localparam int GLYPH_COUNT = 256;
    localparam int GLYPH_ROWS  = 16;
    localparam int ROW_W       = $clog2(GLYPH_ROWS);
    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int GLYPH_W     = 8;

    // Field widths
    localparam int OP_W    = 2;
    localparam int CODE_W  = 8;
    localparam int COORD_W = 12;
    localparam int PITCH_W = 14;
    localparam int WORD_W  = 25;
    localparam int PROD_W  = COORD_W + PITCH_W;
    localparam int COLOR_W = 32;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 96;

    // Cell and cursor constants
    localparam int CELL_W       = 8;
    localparam int CELL_H       = 16;
    localparam int Y_LIMIT      = 4080;
    localparam int NEWLINE_CODE = 10;

    // Operation codes carried in tuser
    localparam logic [OP_W-1:0] OP_LOAD      = 2'd0;
    localparam logic [OP_W-1:0] OP_PRINT     = 2'd1;
    localparam logic [OP_W-1:0] OP_BACKSPACE = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_COLOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCANLINE_PITCH = 2'd3;

    // Configuration reset values
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RST   = 32'hffff_ffff;
    localparam logic [COLOR_W-1:0] CLEAR_COLOR_RST  = 32'h0000_0000;
    localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST = 12'd640;
    localparam logic [PITCH_W-1:0] PITCH_RST        = 14'd640;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_BASE,
        S_EMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_glyph;
        logic newline;
        logic print_cell;
        logic backspace_cell;
        logic calc_prod;
        logic calc_base;
        logic emit_row;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_newline;
        logic at_origin;
        logic out_free;
        logic row_last;
    } t_status;

endpackage

// ===== design/tcgr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the glyph store.
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, re-read every cycle
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/tcgr_ctrl.sv =====
// Controller state machine of the glyph renderer: decodes input beats and
// sequences the sixteen row beats of a cell. Depends on tcgr_pkg.
module tcgr_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [tcgr_pkg::OP_W-1:0] i_op,
    input  tcgr_pkg::t_status        i_status,
    output logic                     o_in_ready,
    output tcgr_pkg::t_cmd           o_cmd
);
    import tcgr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = o_in_ready && i_in_valid;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_op == OP_PRINT && !i_status.is_newline) begin
                        n_state = S_MUL;
                    end else if (i_op == OP_BACKSPACE && !i_status.at_origin) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL:  n_state = S_BASE;
            S_BASE: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.out_free && i_status.row_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.load_glyph     = (i_op == OP_LOAD);
                    o_cmd.newline        = (i_op == OP_PRINT) && i_status.is_newline;
                    o_cmd.print_cell     = (i_op == OP_PRINT) && !i_status.is_newline;
                    o_cmd.backspace_cell = (i_op == OP_BACKSPACE) && !i_status.at_origin;
                end
            end
            S_MUL:  o_cmd.calc_prod = 1'b1;
            S_BASE: o_cmd.calc_base = 1'b1;
            S_EMIT: o_cmd.emit_row  = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== design/tcgr_dpath.sv =====
// Datapath of the glyph renderer: configuration registers, cursor, cell
// address arithmetic and the output register. Depends on tcgr_pkg.
module tcgr_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcgr_pkg::COLOR_W-1:0]      i_cfg_data,
    // input fields
    input  logic [tcgr_pkg::CODE_W-1:0]       i_char_code,
    input  logic [tcgr_pkg::ROW_W-1:0]        i_glyph_row,
    input  logic [tcgr_pkg::GLYPH_W-1:0]      i_glyph_bits,
    // controller link
    input  tcgr_pkg::t_cmd                    i_cmd,
    output tcgr_pkg::t_status                 o_status,
    // glyph store
    output logic                              o_ram_wr_en,
    output logic [tcgr_pkg::STORE_AW-1:0]     o_ram_wr_addr,
    output logic [tcgr_pkg::GLYPH_W-1:0]      o_ram_wr_data,
    output logic [tcgr_pkg::STORE_AW-1:0]     o_ram_rd_addr,
    input  logic [tcgr_pkg::GLYPH_W-1:0]      i_ram_rd_data,
    // result beat
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [tcgr_pkg::COORD_W-1:0]      o_pixel_x,
    output logic [tcgr_pkg::COORD_W-1:0]      o_pixel_y,
    output logic [tcgr_pkg::WORD_W-1:0]       o_word_index,
    output logic [tcgr_pkg::GLYPH_W-1:0]      o_pixel_mask,
    output logic [tcgr_pkg::COLOR_W-1:0]      o_pixel_color,
    output logic                              o_last_row
);
    import tcgr_pkg::*;

    // Configuration registers
    logic [COLOR_W-1:0] r_text_color;
    logic [COLOR_W-1:0] r_clear_color;
    logic [COORD_W-1:0] r_screen_width;
    logic [PITCH_W-1:0] r_pitch;

    // Cursor
    logic [COORD_W-1:0] r_cur_x;
    logic [COORD_W-1:0] r_cur_y;
    logic [COORD_W-1:0] n_cur_x;
    logic [COORD_W-1:0] n_cur_y;

    // Cell in progress
    logic [COORD_W-1:0] r_cell_x;
    logic [COORD_W-1:0] r_cell_y;
    logic [CODE_W-1:0]  r_code;
    logic               r_is_bs;
    logic [COLOR_W-1:0] r_color;
    logic [ROW_W-1:0]   r_row;
    logic [PROD_W-1:0]  r_prod;
    logic [WORD_W-1:0]  r_word;

    // Output register
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic [WORD_W-1:0]  r_out_word;
    logic [GLYPH_W-1:0] r_out_mask;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_last;

    // Cursor arithmetic
    logic [COORD_W:0]   y_plus;
    logic [COORD_W-1:0] y_adv;
    logic [COORD_W:0]   x_plus;
    logic [COORD_W:0]   x_plus2;
    logic               print_wrap;
    logic [COORD_W:0]   bs_sum;
    logic [COORD_W-1:0] bs_x;
    logic [COORD_W-1:0] bs_y;
    logic               code_ok;
    logic [GLYPH_W-1:0] row_mask;

    // Line advance: x to zero, y down one cell, saturating
    assign y_plus = {1'b0, r_cur_y} + (COORD_W+1)'(CELL_H);
    assign y_adv  = (y_plus > (COORD_W+1)'(Y_LIMIT)) ? COORD_W'(Y_LIMIT) : y_plus[COORD_W-1:0];

    // Print advance: wrap when the following cell would not fit
    assign x_plus     = {1'b0, r_cur_x} + (COORD_W+1)'(CELL_W);
    assign x_plus2    = {1'b0, r_cur_x} + (COORD_W+1)'(2 * CELL_W);
    assign print_wrap = x_plus2 > {1'b0, r_screen_width};

    // Backspace step, wrapping up a row
    assign bs_sum = {1'b0, r_cur_x} + {1'b0, r_screen_width};
    always_comb begin
        bs_x = r_cur_x;
        bs_y = r_cur_y;
        if (r_cur_x >= COORD_W'(CELL_W)) begin
            bs_x = r_cur_x - COORD_W'(CELL_W);
        end else begin
            bs_x = (bs_sum >= (COORD_W+1)'(CELL_W))
                 ? COORD_W'(bs_sum - (COORD_W+1)'(CELL_W)) : '0;
            bs_y = (r_cur_y >= COORD_W'(CELL_H)) ? r_cur_y - COORD_W'(CELL_H) : '0;
        end
    end

    // Next cursor; hold it when no command moves it
    always_comb begin
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (i_cmd.newline) begin
            n_cur_x = '0;
            n_cur_y = y_adv;
        end else if (i_cmd.print_cell) begin
            if (print_wrap) begin
                n_cur_x = '0;
                n_cur_y = y_adv;
            end else begin
                n_cur_x = x_plus[COORD_W-1:0];
            end
        end else if (i_cmd.backspace_cell) begin
            n_cur_x = bs_x;
            n_cur_y = bs_y;
        end
    end

    // Configuration writes and cursor update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color   <= TEXT_COLOR_RST;
            r_clear_color  <= CLEAR_COLOR_RST;
            r_screen_width <= SCREEN_WIDTH_RST;
            r_pitch        <= PITCH_RST;
            r_cur_x        <= '0;
            r_cur_y        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_TEXT_COLOR:     r_text_color   <= i_cfg_data;
                    CFG_CLEAR_COLOR:    r_clear_color  <= i_cfg_data;
                    CFG_SCREEN_WIDTH:   r_screen_width <= i_cfg_data[COORD_W-1:0];
                    CFG_SCANLINE_PITCH: r_pitch        <= i_cfg_data[PITCH_W-1:0];
                    default: ;
                endcase
            end
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
        end
    end

    // Capture the cell, then build its first word offset, then step by pitch
    always_ff @(posedge i_clk) begin
        if (i_cmd.print_cell) begin
            r_cell_x <= r_cur_x;
            r_cell_y <= r_cur_y;
            r_code   <= i_char_code;
            r_is_bs  <= 1'b0;
            r_color  <= r_text_color;
            r_row    <= '0;
        end else if (i_cmd.backspace_cell) begin
            r_cell_x <= bs_x;
            r_cell_y <= bs_y;
            r_is_bs  <= 1'b1;
            r_color  <= r_clear_color;
            r_row    <= '0;
        end else if (i_cmd.emit_row) begin
            r_row <= r_row + ROW_W'(1);
        end
        if (i_cmd.calc_prod) begin
            r_prod <= PROD_W'(r_cell_y) * PROD_W'(r_pitch);
        end
        if (i_cmd.calc_base) begin
            r_word <= WORD_W'(PROD_W'(r_cell_x) + r_prod);
        end else if (i_cmd.emit_row) begin
            r_word <= r_word + WORD_W'(r_pitch);
        end
    end

    // Glyph store access; hold the read address until its row is taken
    assign o_ram_wr_en   = i_cmd.load_glyph;
    assign o_ram_wr_addr = STORE_AW'({i_char_code, i_glyph_row});
    assign o_ram_wr_data = i_glyph_bits;
    assign o_ram_rd_addr = STORE_AW'({r_code, i_cmd.emit_row ? r_row + ROW_W'(1) : r_row});

    assign code_ok  = int'(r_code) < GLYPH_COUNT;
    assign row_mask = r_is_bs ? {GLYPH_W{1'b1}} : (code_ok ? i_ram_rd_data : '0);

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_row) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_row) begin
            r_out_x     <= r_cell_x;
            r_out_y     <= r_cell_y + COORD_W'(r_row);
            r_out_word  <= r_word;
            r_out_mask  <= row_mask;
            r_out_color <= r_color;
            r_out_last  <= (r_row == ROW_W'(GLYPH_ROWS - 1));
        end
    end

    // Status to the controller
    assign o_status.is_newline = (i_char_code == CODE_W'(NEWLINE_CODE));
    assign o_status.at_origin  = (r_cur_x == '0) && (r_cur_y == '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.row_last   = (r_row == ROW_W'(GLYPH_ROWS - 1));

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_word_index  = r_out_word;
    assign o_pixel_mask  = r_out_mask;
    assign o_pixel_color = r_out_color;
    assign o_last_row    = r_out_last;

endmodule

// ===== design/text_cell_glyph_renderer.sv =====
// Top level of the text cell glyph renderer: controller, datapath and glyph store.
// Depends on tcgr_pkg, tcgr_ram, tcgr_ctrl and tcgr_dpath.
//
//  channel   direction  handshake                 payload
//  s_axis    in         tvalid / tready           tuser op, tdata glyph load or print
//  m_axis    out        tvalid / tready           tdata row write, tlast sixteenth row
//  cfg       in         i_cfg_wr_en               index 0..3, 32-bit data
//
// Load, newline, backspace at origin and op 3 are taken in idle and leave it idle.
// A printed or erased cell runs these steps: accept, multiply the cell y by pitch,
// form the base offset, then one glyph store row beat a cycle while the output is free.
// Beats stall in the output register while tready is low; the row sequence
// pauses with it. Reset is synchronous; the glyph store is not cleared.
module text_cell_glyph_renderer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input beat
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] char_code, [11:8] glyph_row, [19:12] glyph_bits, [23:20] zero
    input  logic [tcgr_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [1:0] op
    input  logic [tcgr_pkg::OP_W-1:0]          i_s_axis_tuser,
    // result beat
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [11:0] pixel_x, [23:12] pixel_y, [48:24] word_index,
    // [56:49] pixel_mask, [88:57] pixel_color, [95:89] zero
    output logic [tcgr_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    // configuration
    input  logic                               i_cfg_wr_en,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcgr_pkg::COLOR_W-1:0]       i_cfg_data
);
    import tcgr_pkg::*;

    t_cmd               cmd;
    t_status            status;
    logic               ram_wr_en;
    logic [STORE_AW-1:0] ram_wr_addr;
    logic [GLYPH_W-1:0] ram_wr_data;
    logic [STORE_AW-1:0] ram_rd_addr;
    logic [GLYPH_W-1:0] ram_rd_data;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [WORD_W-1:0]  word_index;
    logic [GLYPH_W-1:0] pixel_mask;
    logic [COLOR_W-1:0] pixel_color;

    tcgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_op       (i_s_axis_tuser),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    tcgr_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_char_code   (i_s_axis_tdata[7:0]),
        .i_glyph_row   (i_s_axis_tdata[11:8]),
        .i_glyph_bits  (i_s_axis_tdata[19:12]),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_pixel_x     (pixel_x),
        .o_pixel_y     (pixel_y),
        .o_word_index  (word_index),
        .o_pixel_mask  (pixel_mask),
        .o_pixel_color (pixel_color),
        .o_last_row    (o_m_axis_tlast)
    );

    tcgr_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (STORE_DEPTH)
    ) u_glyph_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Pack the result beat, first field lowest
    assign o_m_axis_tdata = {7'b0, pixel_color, pixel_mask, word_index, pixel_y, pixel_x};

endmodule

// ===== bench/tb_text_cell_glyph_renderer.sv =====
// Self-checking bench for text_cell_glyph_renderer: glyph loads, prints, newlines
// and backspaces in, row beats checked against an in-bench cursor and glyph predictor.
// Depends on tcgr_pkg and the text_cell_glyph_renderer RTL.
`timescale 1ns / 100ps

module tb_text_cell_glyph_renderer;
    import tcgr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [OP_W-1:0]   OP_NONE = 2'd3;
    localparam logic [CODE_W-1:0] LF_CODE = CODE_W'(NEWLINE_CODE);

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [CODE_W-1:0]  code;
        logic [ROW_W-1:0]   row;
        logic [GLYPH_W-1:0] bits;
    } t_char_cmd;

    typedef struct {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [WORD_W-1:0]  word;
        logic [7:0]         mask;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_row_write;

    // DUT connections; the driven inputs are known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COLOR_W-1:0]    cfg_data = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    // Pending commands and rows still owed by the block
    t_char_cmd  cmd_q[$];
    t_char_cmd  cmd_live;
    t_row_write row_writes_due[$];

    // Predictor state and register shadows
    logic [GLYPH_W-1:0] glyph_mem [0:STORE_DEPTH-1];
    int unsigned        cur_x = 0;
    int unsigned        cur_y = 0;
    logic [COLOR_W-1:0] text_col = TEXT_COLOR_RST;
    logic [COLOR_W-1:0] clear_col = CLEAR_COLOR_RST;
    int unsigned        scr_w = 32'(SCREEN_WIDTH_RST);
    int unsigned        pitch = 32'(PITCH_RST);

    // Stimulus bookkeeping: which glyph rows will have been loaded
    bit          row_set [0:STORE_DEPTH-1];
    bit          code_ready [0:GLYPH_COUNT-1];
    int unsigned printable[$];
    int          cmds_made = 0;

    bit idle_en = 1'b1;
    int src_gap = 0;
    int sink_stall = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;

    text_cell_glyph_renderer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        err_cnt++;
        $display("%0t ERROR: %s", $time, msg);
    endtask

    // Queue one row beat for the cell at the cursor
    function automatic void owe_row(input int r, input logic [7:0] mask,
                                    input logic [COLOR_W-1:0] color);
        t_row_write     b;
        int unsigned    y_full;
        longint unsigned w;
        y_full  = cur_y + r;
        b.px    = cur_x[COORD_W-1:0];
        b.py    = y_full[COORD_W-1:0];
        w       = longint'(b.px) + longint'(b.py) * longint'(pitch);
        b.word  = w[WORD_W-1:0];
        b.mask  = mask;
        b.color = color;
        b.last  = (r == CELL_H - 1);
        row_writes_due.push_back(b);
    endfunction

    function automatic void line_feed();
        cur_x = 0;
        cur_y = (cur_y + CELL_H > Y_LIMIT) ? Y_LIMIT : cur_y + CELL_H;
    endfunction

    // Apply one accepted command to the predictor
    function automatic void advance_renderer(input t_char_cmd c);
        int unsigned nx;
        int unsigned sum;
        case (c.op)
            OP_LOAD: begin
                glyph_mem[{c.code, c.row}] = c.bits;
            end
            OP_PRINT: begin
                if (c.code == LF_CODE) begin
                    line_feed();
                end else begin
                    for (int r = 0; r < CELL_H; r++) begin
                        owe_row(r, glyph_mem[{c.code, r[ROW_W-1:0]}], text_col);
                    end
                    nx = cur_x + CELL_W;
                    if (nx + CELL_W > scr_w) line_feed();
                    else cur_x = nx & 32'hfff;
                end
            end
            OP_BACKSPACE: begin
                if (cur_x != 0 || cur_y != 0) begin
                    if (cur_x >= CELL_W) begin
                        cur_x = cur_x - CELL_W;
                    end else begin
                        sum   = cur_x + scr_w;
                        cur_x = (sum >= CELL_W) ? ((sum - CELL_W) & 32'hfff) : 0;
                        cur_y = (cur_y >= CELL_H) ? cur_y - CELL_H : 0;
                    end
                    for (int r = 0; r < CELL_H; r++) begin
                        owe_row(r, 8'hff, clear_col);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Compare one accepted row beat with the oldest owed row
    task automatic check_row_write();
        t_row_write e;
        t_row_write g;
        g.px    = o_m_axis_tdata[11:0];
        g.py    = o_m_axis_tdata[23:12];
        g.word  = o_m_axis_tdata[48:24];
        g.mask  = o_m_axis_tdata[56:49];
        g.color = o_m_axis_tdata[88:57];
        g.last  = o_m_axis_tlast;
        if (row_writes_due.size() == 0) begin
            flag_error($sformatf("row beat with none owed: x=%0d y=%0d", g.px, g.py));
        end else begin
            e = row_writes_due.pop_front();
            if (g.px !== e.px)
                flag_error($sformatf("pixel_x got %0d want %0d", g.px, e.px));
            if (g.py !== e.py)
                flag_error($sformatf("pixel_y got %0d want %0d", g.py, e.py));
            if (g.word !== e.word)
                flag_error($sformatf("word_index got %0d want %0d (x=%0d y=%0d)",
                                     g.word, e.word, e.px, e.py));
            if (g.mask !== e.mask)
                flag_error($sformatf("pixel_mask got %h want %h (x=%0d y=%0d)",
                                     g.mask, e.mask, e.px, e.py));
            if (g.color !== e.color)
                flag_error($sformatf("pixel_color got %h want %h", g.color, e.color));
            if (g.last !== e.last)
                flag_error($sformatf("last_row got %b want %b (y=%0d)",
                                     g.last, e.last, e.py));
        end
    endtask

    // Driver: hold each beat until accepted, insert random gaps between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) advance_renderer(cmd_live);
            if (!s_tvalid || o_s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (idle_en && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 7);
                    s_tvalid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    cmd_live = cmd_q.pop_front();
                    s_tdata  <= {4'b0000, cmd_live.bits, cmd_live.row, cmd_live.code};
                    s_tuser  <= cmd_live.op;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check accepted row beats, stall the result side in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) check_row_write();
            if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_text_cell_glyph_renderer: done, errors");
            $finish;
        end
    end

    // Add one command; track glyphs that become fully loaded and thus printable
    task automatic push_cmd(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                            input logic [ROW_W-1:0] row, input logic [GLYPH_W-1:0] bits);
        t_char_cmd c;
        bit        full;
        c.op   = op;
        c.code = code;
        c.row  = row;
        c.bits = bits;
        cmd_q.push_back(c);
        cmds_made++;
        if (op == OP_LOAD) begin
            row_set[{code, row}] = 1'b1;
            if (!code_ready[code] && code != LF_CODE) begin
                full = 1'b1;
                for (int k = 0; k < GLYPH_ROWS; k++) begin
                    if (!row_set[{code, k[ROW_W-1:0]}]) full = 1'b0;
                end
                if (full) begin
                    code_ready[code] = 1'b1;
                    printable.push_back(32'(code));
                end
            end
        end
    endtask

    task automatic load_glyph(input logic [CODE_W-1:0] code);
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            push_cmd(OP_LOAD, code, r[ROW_W-1:0], GLYPH_W'($urandom_range(0, 255)));
        end
    endtask

    // Random mix: mostly loaded-glyph prints and backspaces, some loads and noise
    task automatic gen_mix(input int n);
        int stop;
        int pick;
        stop = cmds_made + n;
        while (cmds_made < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 12 || printable.size() < 2) begin
                load_glyph(CODE_W'($urandom_range(0, 255)));
            end else if (pick < 17) begin
                push_cmd(OP_LOAD, CODE_W'($urandom_range(0, 255)),
                         ROW_W'($urandom_range(0, 15)), GLYPH_W'($urandom_range(0, 255)));
            end else if (pick < 62) begin
                push_cmd(OP_PRINT, CODE_W'(printable[$urandom_range(0, printable.size() - 1)]),
                         ROW_W'($urandom_range(0, 15)), GLYPH_W'($urandom_range(0, 255)));
            end else if (pick < 72) begin
                push_cmd(OP_PRINT, LF_CODE, ROW_W'($urandom_range(0, 15)),
                         GLYPH_W'($urandom_range(0, 255)));
            end else if (pick < 93) begin
                push_cmd(OP_BACKSPACE, CODE_W'($urandom_range(0, 255)),
                         ROW_W'($urandom_range(0, 15)), GLYPH_W'($urandom_range(0, 255)));
            end else begin
                push_cmd(OP_NONE, CODE_W'($urandom_range(0, 255)),
                         ROW_W'($urandom_range(0, 15)), GLYPH_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // Wait until nothing is owed and the block has settled
    task automatic wait_quiet();
        do begin
            @(posedge i_clk);
            #1;
        end while (cmd_q.size() != 0 || s_tvalid || row_writes_due.size() != 0);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_TEXT_COLOR:   text_col = val;
            CFG_CLEAR_COLOR:  clear_col = val;
            CFG_SCREEN_WIDTH: scr_w = 32'(val[COORD_W-1:0]);
            default:          pitch = 32'(val[PITCH_W-1:0]);
        endcase
    endtask

    task automatic program_regs(input logic [COLOR_W-1:0] tc, input logic [COLOR_W-1:0] cc,
                                input int unsigned w, input int unsigned p);
        write_reg(CFG_TEXT_COLOR, tc);
        write_reg(CFG_CLEAR_COLOR, cc);
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCANLINE_PITCH, p);
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        #1;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        #1;

        // Directed: reset registers, origin and wrap corners
        push_cmd(OP_NONE, 8'hff, 4'hf, 8'hff);
        push_cmd(OP_BACKSPACE, 8'h00, 4'h0, 8'h00);
        push_cmd(OP_PRINT, LF_CODE, 4'h0, 8'h00);
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            case (r)
                0:       push_cmd(OP_LOAD, 8'hff, r[ROW_W-1:0], 8'h00);
                1:       push_cmd(OP_LOAD, 8'hff, r[ROW_W-1:0], 8'hff);
                2:       push_cmd(OP_LOAD, 8'hff, r[ROW_W-1:0], 8'h80);
                3:       push_cmd(OP_LOAD, 8'hff, r[ROW_W-1:0], 8'h01);
                default: push_cmd(OP_LOAD, 8'hff, r[ROW_W-1:0],
                                  GLYPH_W'($urandom_range(0, 255)));
            endcase
        end
        push_cmd(OP_PRINT, 8'hff, 4'h0, 8'h00);
        push_cmd(OP_LOAD, 8'h00, 4'h0, 8'h5a);
        push_cmd(OP_BACKSPACE, 8'h00, 4'h0, 8'h00);
        push_cmd(OP_BACKSPACE, 8'h00, 4'h0, 8'h00);
        push_cmd(OP_PRINT, 8'hff, 4'hf, 8'hff);
        wait_quiet();

        // Narrowest screen and pitch: every print wraps
        program_regs(32'h0000_0000, 32'hffff_ffff, 8, 8);
        gen_mix(30);
        wait_quiet();

        // Widest screen and a large pitch
        program_regs($urandom, $urandom, 4095, 8192);
        gen_mix(30);
        wait_quiet();

        // Push the cursor well down the screen with a wide pitch
        program_regs($urandom, $urandom, 8, 16383);
        for (int k = 0; k < 40; k++) begin
            push_cmd(OP_PRINT, LF_CODE, ROW_W'($urandom_range(0, 15)),
                     GLYPH_W'($urandom_range(0, 255)));
        end
        gen_mix(10);
        wait_quiet();

        // Closing stretch at full rate on both sides
        idle_en = 1'b0;
        program_regs($urandom, $urandom, $urandom_range(8, 4095), $urandom_range(8, 8192));
        gen_mix(25);
        wait_quiet();

        repeat (40) @(posedge i_clk);
        if (err_cnt == 0 && row_writes_due.size() == 0) begin
            $display("tb_text_cell_glyph_renderer: done, clean");
        end else begin
            $display("tb_text_cell_glyph_renderer: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tcgr_pkg.sv
design/tcgr_ram.sv
design/tcgr_ctrl.sv
design/tcgr_dpath.sv
design/text_cell_glyph_renderer.sv
bench/tb_text_cell_glyph_renderer.sv
